// File: design/gsr_pkg.sv
// Shared types, constants and codes for the glyph scanline rasteriser.
// No dependencies; every other design file uses these by scoped name.
package gsr_pkg;

  localparam int LINE_BYTES_DEF  = 50;
  localparam int GLYPH_COUNT_DEF = 96;
  localparam int FONT_WORDS_DEF  = 4096;

  // Item kinds
  localparam logic [1:0] KIND_DRAW        = 2'd0;
  localparam logic [1:0] KIND_LOAD_INDEX  = 2'd1;
  localparam logic [1:0] KIND_LOAD_COLUMN = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_FONT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_HEIGHT = 2'd1;
  localparam logic [5:0]           CHAR_HEIGHT_RST = 6'd16;

  localparam logic [7:0]  CHAR_FIRST = 8'h20;  // first printable code
  localparam logic [7:0]  PIX_MSB    = 8'h80;  // leftmost pixel of a byte
  localparam logic [11:0] ADDR_MASK  = 12'hfff;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  char_code;
    logic [9:0]  char_x;
    logic [8:0]  char_y;
    logic [8:0]  scan_y;
    logic [8:0]  part_y;
    logic        plane_match;
    logic [11:0] table_addr;
    logic [15:0] table_word;
  } in_item_t;

  typedef struct packed {
    logic [10:0] byte_index;
    logic [7:0]  or_bits;
    logic [9:0]  next_char_x;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        large_font;
    logic [5:0]  char_height;
  } cfg_t;

  typedef struct packed {
    logic        idx_we;
    logic        col_we;
    logic [11:0] wr_addr;
    logic [15:0] wr_word;
    logic        idx_re;
    logic [7:0]  idx_addr;
    logic        col_re;
    logic [11:0] col_addr;
  } mem_req_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_COL,
    ST_TAIL
  } state_t;

endpackage

// File: design/gsr_font_store.sv
// Glyph index and glyph column memories, one write and one registered read each.
// Depends on gsr_pkg for the request struct.
module gsr_font_store #(
  parameter int GLYPH_COUNT = gsr_pkg::GLYPH_COUNT_DEF,
  parameter int FONT_WORDS  = gsr_pkg::FONT_WORDS_DEF
) (
  input  logic              clk,
  input  gsr_pkg::mem_req_t req,
  output logic [15:0]       idx_word,
  output logic [15:0]       col_word
);

  localparam int IW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int FW = $clog2(FONT_WORDS);

  logic [15:0] idx_mem [GLYPH_COUNT];
  logic [15:0] col_mem [FONT_WORDS];

  logic [15:0] idx_data_r;
  logic        idx_zero_r;
  logic [15:0] col_data_r;
  logic        col_zero_r;

  logic idx_wr_ok, idx_rd_ok, col_wr_ok, col_rd_ok;

  assign idx_wr_ok = 32'(req.wr_addr)  < GLYPH_COUNT;
  assign idx_rd_ok = 32'(req.idx_addr) < GLYPH_COUNT;
  assign col_wr_ok = 32'(req.wr_addr)  < FONT_WORDS;
  assign col_rd_ok = 32'(req.col_addr) < FONT_WORDS;

  always_ff @(posedge clk) begin
    if (req.idx_we && idx_wr_ok) begin
      idx_mem[req.wr_addr[IW-1:0]] <= req.wr_word;
    end
    if (req.idx_re) begin
      idx_data_r <= idx_mem[req.idx_addr[IW-1:0]];
      idx_zero_r <= !idx_rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (req.col_we && col_wr_ok) begin
      col_mem[req.wr_addr[FW-1:0]] <= req.wr_word;
    end
    if (req.col_re) begin
      col_data_r <= col_mem[req.col_addr[FW-1:0]];
      col_zero_r <= !col_rd_ok;
    end
  end

  // Out-of-range reads answer as zero
  assign idx_word = idx_zero_r ? 16'h0000 : idx_data_r;
  assign col_word = col_zero_r ? 16'h0000 : col_data_r;

endmodule

// File: design/gsr_raster.sv
// Sequencer and shared column-packing step: one glyph column per cycle unless output stalls.
// Depends on gsr_pkg; drives gsr_font_store requests and result transfers.
module gsr_raster #(
  parameter int LINE_BYTES = gsr_pkg::LINE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gsr_pkg::in_item_t  in_data,
  input  gsr_pkg::cfg_t      cfg,
  input  logic [15:0]        idx_word,
  input  logic [15:0]        col_word,
  input  logic               out_free,
  output gsr_pkg::mem_req_t  mem_req,
  output gsr_pkg::emit_t     emit
);

  gsr_pkg::state_t state_r, state_nxt;

  logic [4:0]  issue_cnt_r, issue_cnt_nxt;
  logic [4:0]  proc_cnt_r, proc_cnt_nxt;
  logic        dvld_r, dvld_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  bits_r, bits_nxt;
  logic [10:0] idx_r, idx_nxt;
  logic [9:0]  nx_r, nx_nxt;
  logic [4:0]  w_r, w_nxt;
  logic [11:0] offs_r, offs_nxt;
  logic        row_ok_r, row_ok_nxt;
  logic [3:0]  row_sel_r, row_sel_nxt;
  logic [9:0]  cx_r, cx_nxt;
  logic [8:0]  cy_r, cy_nxt;
  logic [8:0]  sy_r, sy_nxt;
  logic        match_r, match_nxt;
  logic [10:0] prod_r, prod_nxt;

  logic        accept, draw_ok;
  logic [10:0] line_diff;
  logic [4:0]  w_setup;
  logic [9:0]  nx_setup;
  logic        in_rows;
  logic [8:0]  row_raw, row_eff;
  logic [10:0] idx_first;
  logic        stall, last_col, col_bit;
  logic [4:0]  col_off;
  logic [7:0]  bits_merged;

  assign in_ready = (state_r == gsr_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign draw_ok  = (in_data.kind == gsr_pkg::KIND_DRAW) &&
                    ({1'b0, in_data.char_code} >= gsr_pkg::CHAR_FIRST);

  assign line_diff = 11'({2'b00, in_data.scan_y}) - 11'({2'b00, in_data.part_y});

  // Set-up terms, valid while the index word is on the read port
  assign w_setup   = cfg.large_font ? {idx_word[15:12], 1'b0} : {1'b0, idx_word[15:12]};
  assign nx_setup  = 10'(cx_r + 10'(w_setup) + 10'd1);
  assign in_rows   = (sy_r >= cy_r) &&
                     ({1'b0, sy_r} < 10'({1'b0, cy_r} + 10'(cfg.char_height)));
  assign row_raw   = 9'(sy_r - cy_r);
  assign row_eff   = cfg.large_font ? (row_raw >> 1) : row_raw;
  assign idx_first = 11'(11'(cx_r[9:3]) + prod_r);

  // Column step
  assign stall       = dvld_r && (pos_r == 3'd7) && !out_free;
  assign last_col    = (5'(proc_cnt_r + 5'd1) == w_r);
  assign col_off     = cfg.large_font ? (issue_cnt_r >> 1) : issue_cnt_r;
  assign col_bit     = row_ok_r && col_word[4'(4'd15 - row_sel_r)];
  assign bits_merged = col_bit ? (bits_r | (gsr_pkg::PIX_MSB >> pos_r)) : bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gsr_pkg::ST_IDLE;
      issue_cnt_r <= '0;
      proc_cnt_r  <= '0;
      dvld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      proc_cnt_r  <= proc_cnt_nxt;
      dvld_r      <= dvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    bits_r    <= bits_nxt;
    idx_r     <= idx_nxt;
    nx_r      <= nx_nxt;
    w_r       <= w_nxt;
    offs_r    <= offs_nxt;
    row_ok_r  <= row_ok_nxt;
    row_sel_r <= row_sel_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    sy_r      <= sy_nxt;
    match_r   <= match_nxt;
    prod_r    <= prod_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gsr_pkg::ST_IDLE: begin
        if (accept && draw_ok) state_nxt = gsr_pkg::ST_SETUP;
      end
      gsr_pkg::ST_SETUP: begin
        if (!in_rows || !match_r || (w_setup == 5'd0)) state_nxt = gsr_pkg::ST_TAIL;
        else state_nxt = gsr_pkg::ST_COL;
      end
      gsr_pkg::ST_COL: begin
        if (dvld_r && !stall && last_col) begin
          state_nxt = (pos_r == 3'd7) ? gsr_pkg::ST_IDLE : gsr_pkg::ST_TAIL;
        end
      end
      gsr_pkg::ST_TAIL: begin
        if (out_free) state_nxt = gsr_pkg::ST_IDLE;
      end
      default: state_nxt = gsr_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    issue_cnt_nxt = issue_cnt_r;
    proc_cnt_nxt  = proc_cnt_r;
    dvld_nxt      = dvld_r;
    pos_nxt       = pos_r;
    bits_nxt      = bits_r;
    idx_nxt       = idx_r;
    nx_nxt        = nx_r;
    w_nxt         = w_r;
    offs_nxt      = offs_r;
    row_ok_nxt    = row_ok_r;
    row_sel_nxt   = row_sel_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    sy_nxt        = sy_r;
    match_nxt     = match_r;
    prod_nxt      = prod_r;
    mem_req       = '0;
    emit          = '0;

    case (state_r)
      gsr_pkg::ST_IDLE: begin
        if (accept) begin
          cx_nxt    = in_data.char_x;
          cy_nxt    = in_data.char_y;
          sy_nxt    = in_data.scan_y;
          match_nxt = in_data.plane_match;
          prod_nxt  = 11'(line_diff * 11'(LINE_BYTES));
          mem_req.wr_addr  = in_data.table_addr;
          mem_req.wr_word  = in_data.table_word;
          mem_req.idx_we   = (in_data.kind == gsr_pkg::KIND_LOAD_INDEX);
          mem_req.col_we   = (in_data.kind == gsr_pkg::KIND_LOAD_COLUMN);
          mem_req.idx_re   = draw_ok;
          mem_req.idx_addr = 8'({1'b0, in_data.char_code} - gsr_pkg::CHAR_FIRST);
        end
      end
      gsr_pkg::ST_SETUP: begin
        w_nxt         = w_setup;
        offs_nxt      = idx_word[11:0];
        row_ok_nxt    = (row_eff < 9'd16);
        row_sel_nxt   = row_eff[3:0];
        issue_cnt_nxt = '0;
        proc_cnt_nxt  = '0;
        dvld_nxt      = 1'b0;
        bits_nxt      = '0;
        pos_nxt       = cx_r[2:0];
        if (!in_rows) begin
          idx_nxt = '0;
          nx_nxt  = nx_setup;
        end else if (!match_r) begin
          idx_nxt = '0;
          nx_nxt  = cx_r;
        end else begin
          idx_nxt = idx_first;
          nx_nxt  = nx_setup;
        end
      end
      gsr_pkg::ST_COL: begin
        if (!stall) begin
          // issue the next column read
          if (issue_cnt_r < w_r) begin
            mem_req.col_re   = 1'b1;
            mem_req.col_addr = 12'(offs_r + 12'(col_off)) & gsr_pkg::ADDR_MASK;
            issue_cnt_nxt    = 5'(issue_cnt_r + 5'd1);
            dvld_nxt         = 1'b1;
          end else begin
            dvld_nxt = 1'b0;
          end
          // merge the column that has arrived
          if (dvld_r) begin
            proc_cnt_nxt = 5'(proc_cnt_r + 5'd1);
            if (pos_r == 3'd7) begin
              emit.valid            = 1'b1;
              emit.item.byte_index  = idx_r;
              emit.item.or_bits     = bits_merged;
              emit.item.next_char_x = nx_r;
              emit.item.last        = last_col;
              idx_nxt  = 11'(idx_r + 11'd1);
              bits_nxt = '0;
              pos_nxt  = 3'd0;
            end else begin
              bits_nxt = bits_merged;
              pos_nxt  = 3'(pos_r + 3'd1);
            end
          end
        end
      end
      gsr_pkg::ST_TAIL: begin
        if (out_free) begin
          emit.valid            = 1'b1;
          emit.item.byte_index  = idx_r;
          emit.item.or_bits     = bits_r;
          emit.item.next_char_x = nx_r;
          emit.item.last        = 1'b1;
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> out_free)
    else $error("result produced while output register is occupied");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gsr_pkg::ST_COL) |-> (issue_cnt_r <= w_r))
    else $error("more column reads issued than glyph columns");

  a_proc_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gsr_pkg::ST_COL && dvld_r) |-> (5'(proc_cnt_r + 5'd1) == issue_cnt_r))
    else $error("column merge out of step with column reads");

  a_col_width: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gsr_pkg::ST_COL) |-> (w_r != 5'd0))
    else $error("column loop entered with zero width");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gsr_pkg::ST_COL && stall) |=> $stable(proc_cnt_r) && $stable(issue_cnt_r))
    else $error("column loop advanced during a stall");
`endif

endmodule

// File: design/glyph_scanline_rasterizer_core.sv
// Sequence: load items and ignored items are handled in the idle state; a draw reads the
// index, sets up, reads one glyph column a cycle unless the output stalls, and merges each
// column when its registered read data arrives; a glyph is w columns wide (w up to 15, 30
// in large mode); the tail state sends a part byte left at the end or a skipped draw's empty byte.
// Throughput: one item at a time; in_ready is low until the draw's last result is formed.
// Reset (rst_n, synchronous, active low) clears the sequencer, large_font and out_valid and sets
// char_height to 16; font stores are not cleared and hold undefined data until loaded.
module glyph_scanline_rasterizer_core #(
  parameter int LINE_BYTES  = gsr_pkg::LINE_BYTES_DEF,
  parameter int GLYPH_COUNT = gsr_pkg::GLYPH_COUNT_DEF,
  parameter int FONT_WORDS  = gsr_pkg::FONT_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  gsr_pkg::in_item_t                in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output gsr_pkg::out_item_t               out_data,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gsr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                large_font_r, large_font_nxt;
  logic [5:0]          char_height_r, char_height_nxt;
  logic                out_valid_r, out_valid_nxt;
  gsr_pkg::out_item_t  out_data_r, out_data_nxt;

  gsr_pkg::cfg_t       cfg;
  gsr_pkg::mem_req_t   mem_req;
  gsr_pkg::emit_t      emit;
  logic [15:0]         idx_word, col_word;
  logic                out_free;

  // The user must send configuration writes only between items (unchecked); every transfer is taken at once
  assign cfg_ready = 1'b1;

  always_comb begin
    large_font_nxt  = large_font_r;
    char_height_nxt = char_height_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gsr_pkg::CFG_LARGE_FONT:  large_font_nxt  = cfg_data[0];
        gsr_pkg::CFG_CHAR_HEIGHT: char_height_nxt = cfg_data[5:0];
        default: begin
          // drop writes to unused indexes
          large_font_nxt = large_font_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_font_r  <= 1'b0;
      char_height_r <= gsr_pkg::CHAR_HEIGHT_RST;
    end else begin
      large_font_r  <= large_font_nxt;
      char_height_r <= char_height_nxt;
    end
  end

  assign cfg.large_font  = large_font_r;
  assign cfg.char_height = char_height_r;

  // Output register: free when empty or when its result is being transferred
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit.valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit.item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gsr_font_store #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .FONT_WORDS  (FONT_WORDS)
  ) u_font_store (
    .clk      (clk),
    .req      (mem_req),
    .idx_word (idx_word),
    .col_word (col_word)
  );

  gsr_raster #(
    .LINE_BYTES (LINE_BYTES)
  ) u_raster (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .idx_word (idx_word),
    .col_word (col_word),
    .out_free (out_free),
    .mem_req  (mem_req),
    .emit     (emit)
  );

endmodule
